FILE: hdl/assert_macros.svh
// Assertion macros for the deframer RTL.
// Included by trace_packet_deframer_core, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define TPD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define TPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TPD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hdl/tpd_pkg.sv
// Types and constants of the trace packet deframer.
// No dependencies; used by the core, front end, job queue and back end of the block.
package tpd_pkg;

	// result status codes
	localparam logic [1:0] STATUS_PACKET   = 2'd0;
	localparam logic [1:0] STATUS_UNSYNC   = 2'd1;
	localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MAGIC_PLAIN  = 2'd0;
	localparam logic [1:0] REG_MAGIC_CYCLES = 2'd1;
	localparam logic [1:0] REG_CHANNEL_ID   = 2'd2;

	// microseconds to nanoseconds
	localparam logic [9:0] CYCLE_SCALE = 10'd1000;

	// one finished packet or status event waiting for the back end
	typedef struct packed {
		logic [1:0]  status;
		logic [62:0] timestamp_ns;
		logic [31:0] tag_word;
		logic [15:0] line_number;
		logic [3:0]  payload_count;
		logic        bank;
	} job_t;

	// payload store write from the front end
	typedef struct packed {
		logic        en;
		logic        bank;
		logic [3:0]  index;
		logic [31:0] data;
	} store_wr_t;

	// back end hands a payload bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_free_t;

endpackage

FILE: hdl/tpd_ifs.sv
// Stream interfaces of the trace packet deframer: word input and result output.
// No dependencies.
interface tpd_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] trace_word;
	logic [62:0] arrival_time_ns;

	modport source (output valid, trace_word, arrival_time_ns, input ready);
	modport sink (input valid, trace_word, arrival_time_ns, output ready);
endinterface

interface tpd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  channel;
	logic [62:0] timestamp_ns;
	logic [31:0] tag_word;
	logic [15:0] line_number;
	logic [3:0]  payload_count;
	logic [3:0]  word_index;
	logic [31:0] payload_word;
	logic        last;

	modport source (output valid, status, channel, timestamp_ns, tag_word, line_number,
		payload_count, word_index, payload_word, last, input ready);
	modport sink (input valid, status, channel, timestamp_ns, tag_word, line_number,
		payload_count, word_index, payload_word, last, output ready);
endinterface

FILE: hdl/trace_packet_deframer_core.sv
// Trace packet deframer. Accepts one trace word per cycle; the front end frames
// packets and stalls only when its two-entry job queue is full, or when a payload
// word would go into a bank the back end still reads (two banks of MAX_PAYLOAD
// words). The back end emits one result per cycle while the sink is ready: a packet
// of n payload words gives n results, every other event one, each passing through the
// job queue, the payload read stage and the output register. Each result comes from
// an input word, so sustained input rate is one word per cycle while the sink takes
// results. Depends on tpd_pkg, tpd_ifs, assert_macros.svh, tpd_front, tpd_job_q and tpd_back.
`include "assert_macros.svh"
module trace_packet_deframer_core #(
	parameter int MAX_PAYLOAD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tpd_in_if.sink      in_ch,
	tpd_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [31:0] magic_plain_q;
	logic [31:0] magic_cycles_q;
	logic [7:0]  channel_id_q;

	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	tpd_pkg::job_t       job_in;
	tpd_pkg::job_t       job_out;
	tpd_pkg::store_wr_t  store_wr;
	tpd_pkg::bank_free_t bank_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_plain_q  <= '0;
			magic_cycles_q <= '0;
			channel_id_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpd_pkg::REG_MAGIC_PLAIN:  magic_plain_q  <= cfg_wdata;
				tpd_pkg::REG_MAGIC_CYCLES: magic_cycles_q <= cfg_wdata;
				tpd_pkg::REG_CHANNEL_ID:   channel_id_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	tpd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_ch             (in_ch),
		.magic_plain       (magic_plain_q),
		.magic_with_cycles (magic_cycles_q),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_job             (job_in),
		.store_wr          (store_wr),
		.bank_free         (bank_free)
	);

	tpd_job_q u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.job_in  (job_in),
		.full    (q_full),
		.pop     (q_pop),
		.job_out (job_out),
		.empty   (q_empty)
	);

	tpd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.channel_id (channel_id_q),
		.q_empty    (q_empty),
		.q_job      (job_out),
		.q_pop      (q_pop),
		.store_wr   (store_wr),
		.bank_free  (bank_free),
		.out_ch     (out_ch)
	);

	// queue never overruns or underruns
	`TPD_ASSERT_NEVER(a_queue_overflow, clk, arst_n, q_push && q_full)
	`TPD_ASSERT_NEVER(a_queue_underflow, clk, arst_n, q_pop && q_empty)
	// payload results stay inside their packet
	`TPD_ASSERT_IMPLIES(a_index_in_packet, clk, arst_n, out_ch.valid && out_ch.status == tpd_pkg::STATUS_PACKET && out_ch.payload_count != 4'd0, out_ch.word_index < out_ch.payload_count)

endmodule

FILE: hdl/tpd_front.sv
// Front end of the deframer: framing state machine, payload store writes, job creation.
// Depends on tpd_pkg and tpd_in_if.
module tpd_front #(
	parameter int MAX_PAYLOAD = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tpd_in_if.sink               in_ch,
	input  logic [31:0]          magic_plain,
	input  logic [31:0]          magic_with_cycles,
	input  logic                 q_full,
	output logic                 q_push,
	output tpd_pkg::job_t        q_job,
	output tpd_pkg::store_wr_t   store_wr,
	input  tpd_pkg::bank_free_t  bank_free
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_CYCLES = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_TAG    = 3'd3;
	localparam logic [2:0] PH_WORDS  = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [41:0] cycle_ns_q;
	logic [15:0] line_q;
	logic [3:0]  expected_q;
	logic [31:0] tag_q;
	logic [3:0]  received_q;
	logic        bank_q;
	logic [1:0]  busy_q;

	logic        accept;
	logic [31:0] word;
	logic [62:0] arrival;
	logic [3:0]  hdr_count;
	logic        pl_done;

	// stall while the queue is full or the bank to be filled still drains
	assign in_ch.ready = !q_full && !(phase_q == PH_WORDS && busy_q[bank_q]);
	assign accept      = in_ch.valid && in_ch.ready;
	assign word        = in_ch.trace_word;
	assign arrival     = in_ch.arrival_time_ns;
	assign hdr_count   = word[31:28];
	assign pl_done     = (received_q + 4'd1) == expected_q;

	// classify the word and build the job for the back end
	always_comb begin
		phase_d = phase_q;
		q_push  = 1'b0;
		q_job   = '0;
		q_job.bank = bank_q;
		store_wr = '0;
		store_wr.bank  = bank_q;
		store_wr.index = received_q;
		store_wr.data  = word;
		case (phase_q)
			PH_IDLE: begin
				if (word == magic_plain) begin
					phase_d = PH_HEADER;
				end else if (word == magic_with_cycles) begin
					phase_d = PH_CYCLES;
				end else begin
					q_push             = accept;
					q_job.status       = tpd_pkg::STATUS_UNSYNC;
					q_job.timestamp_ns = arrival;
				end
			end
			PH_CYCLES: begin
				phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				if (hdr_count > 4'(MAX_PAYLOAD)) begin
					phase_d             = PH_IDLE;
					q_push              = accept;
					q_job.status        = tpd_pkg::STATUS_BAD_SIZE;
					q_job.timestamp_ns  = arrival;
					q_job.line_number   = word[15:0];
					q_job.payload_count = hdr_count;
				end else begin
					phase_d = PH_TAG;
				end
			end
			PH_TAG: begin
				if (expected_q == 4'd0) begin
					phase_d            = PH_IDLE;
					q_push             = accept;
					q_job.status       = tpd_pkg::STATUS_PACKET;
					q_job.timestamp_ns = arrival;
					q_job.tag_word     = word;
					q_job.line_number  = line_q;
				end else begin
					phase_d = PH_WORDS;
				end
			end
			PH_WORDS: begin
				store_wr.en = accept;
				if (pl_done) begin
					phase_d             = PH_IDLE;
					q_push              = accept;
					q_job.status        = tpd_pkg::STATUS_PACKET;
					q_job.timestamp_ns  = (cycle_ns_q != '0) ? {21'd0, cycle_ns_q} : arrival;
					q_job.tag_word      = tag_q;
					q_job.line_number   = line_q;
					q_job.payload_count = expected_q;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// advance the framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cycle_ns_q <= '0;
			line_q     <= '0;
			expected_q <= '0;
			tag_q      <= '0;
			received_q <= '0;
			bank_q     <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_IDLE: begin
					received_q <= '0;
				end
				PH_CYCLES: begin
					cycle_ns_q <= 42'(word) * 42'(tpd_pkg::CYCLE_SCALE);
				end
				PH_HEADER: begin
					line_q     <= word[15:0];
					expected_q <= hdr_count;
				end
				PH_TAG: begin
					tag_q      <= word;
					received_q <= '0;
				end
				PH_WORDS: begin
					received_q <= received_q + 4'd1;
					if (pl_done) begin
						bank_q <= !bank_q;
					end
				end
				default: begin
					received_q <= '0;
				end
			endcase
		end
	end

	// track which payload banks the back end still reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (bank_free.valid) begin
				busy_q[bank_free.bank] <= 1'b0;
			end
			if (accept && phase_q == PH_WORDS && pl_done) begin
				busy_q[bank_q] <= 1'b1;
			end
		end
	end

endmodule

FILE: hdl/tpd_job_q.sv
// Two-entry job queue between the front and back ends of the deframer.
// Depends on tpd_pkg.
module tpd_job_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpd_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output tpd_pkg::job_t job_out,
	output logic          empty
);

	tpd_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign job_out = entry_q[rd_ptr_q];

	// hold jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job_in;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: hdl/tpd_back.sv
// Back end of the deframer: payload store and result sequencer with output register.
// Depends on tpd_pkg and tpd_out_if.
module tpd_back #(
	parameter int MAX_PAYLOAD = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           channel_id,
	input  logic                 q_empty,
	input  tpd_pkg::job_t        q_job,
	output logic                 q_pop,
	input  tpd_pkg::store_wr_t   store_wr,
	output tpd_pkg::bank_free_t  bank_free,
	tpd_out_if.source            out_ch
);

	localparam int Depth = 2 * MAX_PAYLOAD;
	localparam int AW    = $clog2(Depth);

	logic [31:0] mem [Depth];

	logic [3:0]    idx_q;
	logic          s1_valid_q;
	tpd_pkg::job_t job_s1;
	logic [3:0]    idx_s1;
	logic          last_s1;
	logic          has_pl_s1;
	logic [31:0]   rd_data_s1;

	logic          out_valid_q;
	logic [1:0]    status_q;
	logic [62:0]   ts_q;
	logic [31:0]   tag_q;
	logic [15:0]   line_q;
	logic [3:0]    count_q;
	logic [3:0]    index_q;
	logic [31:0]   payload_q;
	logic          last_q;

	logic          out_move;
	logic          issue;
	logic          has_pl;
	logic          is_last;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign out_move = !out_valid_q || out_ch.ready;
	assign issue    = !q_empty && (!s1_valid_q || out_move);
	assign has_pl   = q_job.status == tpd_pkg::STATUS_PACKET && q_job.payload_count != 4'd0;
	assign is_last  = has_pl ? (idx_q == q_job.payload_count - 4'd1) : 1'b1;
	assign q_pop    = issue && is_last;

	assign bank_free.valid = q_pop && has_pl;
	assign bank_free.bank  = q_job.bank;

	// bank one starts after bank zero
	assign wr_addr = store_wr.bank ? AW'(MAX_PAYLOAD) + AW'(store_wr.index)
		: AW'(store_wr.index);
	assign rd_addr = q_job.bank ? AW'(MAX_PAYLOAD) + AW'(idx_q) : AW'(idx_q);

	// payload store: write from the front, registered read for the sequencer
	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem[wr_addr] <= store_wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
			job_s1     <= q_job;
			idx_s1     <= idx_q;
			last_s1    <= is_last;
			has_pl_s1  <= has_pl;
		end
	end

	// step through the words of the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= is_last ? 4'd0 : idx_q + 4'd1;
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (out_move) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// output register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_move) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_move && s1_valid_q) begin
			status_q  <= job_s1.status;
			ts_q      <= job_s1.timestamp_ns;
			tag_q     <= job_s1.tag_word;
			line_q    <= job_s1.line_number;
			count_q   <= job_s1.payload_count;
			index_q   <= idx_s1;
			payload_q <= has_pl_s1 ? rd_data_s1 : 32'd0;
			last_q    <= last_s1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.channel       = channel_id;
	assign out_ch.timestamp_ns  = ts_q;
	assign out_ch.tag_word      = tag_q;
	assign out_ch.line_number   = line_q;
	assign out_ch.payload_count = count_q;
	assign out_ch.word_index    = index_q;
	assign out_ch.payload_word  = payload_q;
	assign out_ch.last          = last_q;

endmodule
